[rtl/csc_pkg.sv]
// shared types and constants for the countdown/stopwatch controller
// no dependencies
`timescale 1ns / 1ps

package csc_pkg;

    localparam int ENTRY_MAX_DEF = 12;
    localparam logic [15:0] ALARM_RESET = 16'd2000;
    localparam logic [26:0] TOTAL_RESET = 27'd300000;
    localparam logic [39:0] DAY_MS = 40'd86400000;
    localparam logic [40:0] VALUE_CAP = 41'h100_0000_0000;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_RUN = 3'd1;
    localparam logic [2:0] PH_PAUSED = 3'd2;
    localparam logic [2:0] PH_FINISHED = 3'd3;
    localparam logic [2:0] PH_SETTING = 3'd4;
    localparam logic [2:0] PH_SW_IDLE = 3'd5;
    localparam logic [2:0] PH_SW_RUN = 3'd6;
    localparam logic [2:0] PH_SW_PAUSED = 3'd7;

    localparam logic [7:0] K_ESC = 8'd27;
    localparam logic [7:0] K_LF = 8'd10;
    localparam logic [7:0] K_CR = 8'd13;
    localparam logic [7:0] K_DEL = 8'd127;
    localparam logic [7:0] K_BS = 8'd8;
    localparam logic [7:0] K_ETX = 8'd3;
    localparam logic [7:0] K_EOT = 8'd4;

    // parser status between top and parser
    typedef struct packed {
        logic        done;
        logic        ok;
        logic [26:0] value;
    } parse_res_t;

    function automatic logic [40:0] cap41(input logic [46:0] v);
        cap41 = (v > 47'(VALUE_CAP)) ? VALUE_CAP : v[40:0];
    endfunction

endpackage

[rtl/csc_parser.sv]
// duration parser: walks the entry one character per cycle
// depends on csc_pkg
`timescale 1ns / 1ps

module csc_parser #(
    parameter int ENTRY_MAX = csc_pkg::ENTRY_MAX_DEF,
    parameter int CW = $clog2(ENTRY_MAX + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [CW-1:0]            count,
    input  logic [ENTRY_MAX-1:0][7:0] chars,
    output csc_pkg::parse_res_t      res
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_FIN  = 3'b100
    } pstate_t;

    pstate_t     state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [40:0] total_reg, total_next, seg_reg, seg_next;
    logic [1:0]  colons_reg, colons_next, dots_reg, dots_next, frac_reg, frac_next;
    logic        any_reg, any_next, bad_reg, bad_next;
    logic        done_reg, done_next, ok_reg, ok_next;
    logic [26:0] val_reg, val_next;
    logic [7:0]  c;
    logic [3:0]  dig;
    logic [40:0] fin;

    always_comb
    begin
        c = chars[idx_reg[$clog2(ENTRY_MAX)-1:0]];
        dig = c[3:0];
        fin = csc_pkg::cap41(47'(total_reg) * 47'd60 + 47'(seg_reg));
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        total_next = total_reg;
        seg_next = seg_reg;
        colons_next = colons_reg;
        dots_next = dots_reg;
        frac_next = frac_reg;
        any_next = any_reg;
        bad_next = bad_reg;
        done_next = 1'b0;
        ok_next = ok_reg;
        val_next = val_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    idx_next = '0;
                    total_next = '0;
                    seg_next = '0;
                    colons_next = '0;
                    dots_next = '0;
                    frac_next = '0;
                    any_next = 1'b0;
                    bad_next = (count == '0);
                    state_next = (count == '0) ? S_FIN : S_WALK;
                end
            end
            S_WALK:
            begin
                if (c >= "0" && c <= "9")
                begin
                    any_next = 1'b1;
                    if (dots_reg == 2'd0)
                        seg_next = csc_pkg::cap41(47'(seg_reg) * 47'd10 + 47'(dig) * 47'd1000);
                    else if (dots_reg == 2'd1 && frac_reg < 2'd3)
                    begin
                        seg_next = csc_pkg::cap41(47'(seg_reg) + 47'(dig) *
                            ((frac_reg == 2'd0) ? 47'd100 : (frac_reg == 2'd1) ? 47'd10 : 47'd1));
                        frac_next = frac_reg + 2'd1;
                    end
                end
                else if (c == ".")
                begin
                    if (dots_reg < 2'd2)
                        dots_next = dots_reg + 2'd1;
                end
                else if (c == ":")
                begin
                    if (colons_reg >= 2'd2)
                        bad_next = 1'b1;
                    total_next = fin;
                    seg_next = '0;
                    dots_next = '0;
                    frac_next = '0;
                    colons_next = colons_reg + 2'd1;
                end
                else
                    bad_next = 1'b1;
                idx_next = idx_reg + CW'(1);
                if (bad_next || idx_next == count)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                done_next = 1'b1;
                ok_next = !bad_reg && any_reg && fin != '0 && 40'(fin) <= csc_pkg::DAY_MS
                    && fin[40] == 1'b0;
                val_next = fin[26:0];
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        total_reg <= total_next;
        seg_reg <= seg_next;
        colons_reg <= colons_next;
        dots_reg <= dots_next;
        frac_reg <= frac_next;
        any_reg <= any_next;
        bad_reg <= bad_next;
        ok_reg <= ok_next;
        val_reg <= val_next;
    end

    assign res.done = done_reg;
    assign res.ok = ok_reg;
    assign res.value = val_reg;

endmodule

[rtl/countdown_stopwatch_controller.sv]
// countdown timer / stopwatch controller, top level
// a tick or key passes S_APPLY, S_EXPIRE and S_OUT; enter also walks the entry in S_PARSE
// one transaction at a time: no new tick or key is accepted until the result is taken
// reset: asynchronous active low; 5 min countdown, idle, alarm interval 2000
// depends on csc_pkg, csc_parser
`timescale 1ns / 1ps

module countdown_stopwatch_controller #(
    parameter int ENTRY_MAX = csc_pkg::ENTRY_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [7:0]  key_code,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        mode_now,
    output logic [2:0]  phase_code,
    output logic [31:0] time_ms,
    output logic        beep,
    output logic        quit_request,
    output logic        entry_bad,
    output logic [3:0]  entry_length,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    localparam int CW = $clog2(ENTRY_MAX + 1);
    localparam int IW = $clog2(ENTRY_MAX);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_APPLY  = 5'b00010,
        S_PARSE  = 5'b00100,
        S_EXPIRE = 5'b01000,
        S_OUT    = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    logic [15:0] alarm_int_reg;
    logic        mode_reg;
    logic [2:0]  phase_reg;
    logic [26:0] total_reg;
    logic [31:0] base_reg, run_reg;
    logic [15:0] alarm_reg;
    logic [ENTRY_MAX-1:0][7:0] chars_reg;
    logic [CW-1:0] count_reg;
    logic        err_reg;
    logic        req_reg;
    logic [7:0]  key_reg;
    logic        beep_reg, quit_reg;
    logic [31:0] time_val;
    logic        pstart;
    csc_pkg::parse_res_t pres;

    logic        running;
    logic [32:0] sum;
    logic [31:0] elapsed;
    logic        is_digit;

    function automatic logic quit_w();
        quit_w = req_reg && (key_reg == "q" || key_reg == "Q"
            || key_reg == csc_pkg::K_ETX || key_reg == csc_pkg::K_EOT);
    endfunction

    csc_parser #(.ENTRY_MAX(ENTRY_MAX), .CW(CW)) u_parser (
        .clk(clk), .rst_n(rst_n), .start(pstart), .count(count_reg),
        .chars(chars_reg), .res(pres)
    );

    always_comb
    begin
        running = phase_reg == csc_pkg::PH_RUN || phase_reg == csc_pkg::PH_SW_RUN;
        sum = {1'b0, base_reg} + {1'b0, run_reg};
        elapsed = running ? (sum[32] ? 32'hFFFF_FFFF : sum[31:0]) : base_reg;
        is_digit = key_reg >= "0" && key_reg <= "9";
        state_next = state_reg;
        pstart = 1'b0;
        unique case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_APPLY;
            S_APPLY:
            begin
                if (req_reg && phase_reg == csc_pkg::PH_SETTING
                    && (key_reg == csc_pkg::K_LF || key_reg == csc_pkg::K_CR)
                    && !quit_w())
                begin
                    pstart = 1'b1;
                    state_next = S_PARSE;
                end
                else
                    state_next = S_EXPIRE;
            end
            S_PARSE:  if (pres.done) state_next = S_EXPIRE;
            S_EXPIRE: state_next = S_OUT;
            S_OUT:    if (out_ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            alarm_int_reg <= csc_pkg::ALARM_RESET;
            mode_reg <= 1'b0;
            phase_reg <= csc_pkg::PH_IDLE;
            total_reg <= csc_pkg::TOTAL_RESET;
            base_reg <= '0;
            run_reg <= '0;
            alarm_reg <= '0;
            count_reg <= '0;
            err_reg <= 1'b0;
            beep_reg <= 1'b0;
            quit_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                alarm_int_reg <= cfg_wdata;
            unique case (state_reg)
                S_IDLE:
                begin
                    beep_reg <= 1'b0;
                    quit_reg <= 1'b0;
                end
                S_APPLY:
                begin
                    if (!req_reg)
                    begin
                        if (running && run_reg != 32'hFFFF_FFFF)
                            run_reg <= run_reg + 32'd1;
                        if (phase_reg == csc_pkg::PH_FINISHED)
                        begin
                            if (alarm_reg >= alarm_int_reg)
                            begin
                                beep_reg <= 1'b1;
                                alarm_reg <= '0;
                            end
                            else
                                alarm_reg <= alarm_reg + 16'd1;
                        end
                    end
                    else if (quit_w())
                        quit_reg <= 1'b1;
                    else if (phase_reg == csc_pkg::PH_SETTING)
                    begin
                        if (key_reg == csc_pkg::K_ESC)
                        begin
                            count_reg <= '0;
                            err_reg <= 1'b0;
                            phase_reg <= csc_pkg::PH_IDLE;
                        end
                        else if (key_reg == csc_pkg::K_DEL || key_reg == csc_pkg::K_BS)
                        begin
                            if (count_reg != '0)
                                count_reg <= count_reg - CW'(1);
                            err_reg <= 1'b0;
                        end
                        else if (is_digit || key_reg == ":" || key_reg == ".")
                        begin
                            if (count_reg < CW'(ENTRY_MAX))
                                count_reg <= count_reg + CW'(1);
                            err_reg <= 1'b0;
                        end
                    end
                    else
                    begin
                        case (key_reg)
                            " ", "p", "P":
                            begin
                                run_reg <= '0;
                                case (phase_reg)
                                    csc_pkg::PH_IDLE, csc_pkg::PH_PAUSED:
                                        phase_reg <= csc_pkg::PH_RUN;
                                    csc_pkg::PH_SW_IDLE, csc_pkg::PH_SW_PAUSED:
                                        phase_reg <= csc_pkg::PH_SW_RUN;
                                    csc_pkg::PH_RUN:
                                    begin
                                        base_reg <= elapsed;
                                        phase_reg <= csc_pkg::PH_PAUSED;
                                    end
                                    csc_pkg::PH_SW_RUN:
                                    begin
                                        base_reg <= elapsed;
                                        phase_reg <= csc_pkg::PH_SW_PAUSED;
                                    end
                                    csc_pkg::PH_FINISHED:
                                    begin
                                        base_reg <= '0;
                                        phase_reg <= csc_pkg::PH_IDLE;
                                    end
                                    default: ;
                                endcase
                            end
                            "n", "N":
                            begin
                                if (!mode_reg)
                                begin
                                    run_reg <= '0;
                                    count_reg <= '0;
                                    err_reg <= 1'b0;
                                    phase_reg <= csc_pkg::PH_SETTING;
                                end
                            end
                            "s", "S":
                            begin
                                base_reg <= '0;
                                run_reg <= '0;
                                phase_reg <= mode_reg ? csc_pkg::PH_SW_IDLE : csc_pkg::PH_IDLE;
                            end
                            "m", "M":
                            begin
                                mode_reg <= !mode_reg;
                                base_reg <= '0;
                                run_reg <= '0;
                                phase_reg <= mode_reg ? csc_pkg::PH_IDLE : csc_pkg::PH_SW_IDLE;
                            end
                            default: ;
                        endcase
                    end
                end
                S_PARSE:
                begin
                    if (pres.done)
                    begin
                        if (pres.ok)
                        begin
                            total_reg <= pres.value;
                            base_reg <= '0;
                            run_reg <= '0;
                            phase_reg <= csc_pkg::PH_IDLE;
                        end
                        else
                            err_reg <= 1'b1;
                    end
                end
                S_EXPIRE:
                begin
                    // expiry check, skipped for quit keys
                    if (!quit_reg && !mode_reg && running && elapsed >= 32'(total_reg))
                    begin
                        base_reg <= 32'(total_reg);
                        run_reg <= '0;
                        phase_reg <= csc_pkg::PH_FINISHED;
                        alarm_reg <= '0;
                        beep_reg <= 1'b1;
                    end
                end
                S_OUT: ;
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            req_reg <= req_type;
            key_reg <= key_code;
        end
        if (state_reg == S_APPLY && req_reg && !quit_w() && phase_reg == csc_pkg::PH_SETTING
            && (is_digit || key_reg == ":" || key_reg == ".") && count_reg < CW'(ENTRY_MAX))
            chars_reg[count_reg[IW-1:0]] <= key_reg;
    end

    // time output computed once the state settles
    always_comb
    begin
        if (mode_reg)
            time_val = elapsed;
        else
            time_val = (elapsed < 32'(total_reg)) ? 32'(total_reg) - elapsed : 32'd0;
    end

    assign in_ready = state_reg == S_IDLE;
    assign out_valid = state_reg == S_OUT;
    assign mode_now = mode_reg;
    assign phase_code = phase_reg;
    assign time_ms = time_val;
    assign beep = beep_reg;
    assign quit_request = quit_reg;
    assign entry_bad = err_reg;
    assign entry_length = 4'(count_reg);

endmodule

[rtl/csc_checker.sv]
// port-level checker for the countdown/stopwatch controller, with bind
// depends on csc_pkg and the countdown_stopwatch_controller ports
`timescale 1ns / 1ps

module csc_checker #(
    parameter int ENTRY_MAX = csc_pkg::ENTRY_MAX_DEF
) (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        mode_now,
    input logic [2:0]  phase_code,
    input logic [3:0]  entry_length
);

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("ready while result pending");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready) else $error("second transaction while busy");

    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");

    a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, entry_length} <= 5'(ENTRY_MAX)) else $error("entry too long");

    a_mode_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mode_now |-> phase_code == csc_pkg::PH_SW_IDLE
        || phase_code == csc_pkg::PH_SW_RUN
        || phase_code == csc_pkg::PH_SW_PAUSED) else $error("stopwatch phase mismatch");

endmodule

bind countdown_stopwatch_controller csc_checker #(.ENTRY_MAX(ENTRY_MAX)) u_csc_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .mode_now(mode_now),
    .phase_code(phase_code), .entry_length(entry_length)
);

[verif/testbench.sv]
// self-checking testbench for countdown_stopwatch_controller
// depends on csc_pkg and the controller rtl; carries its own timer/stopwatch predictor
`timescale 1ns / 1ps

module testbench;

    localparam int TIMEOUT_CYCLES = 3000;
    localparam int DRAIN_CYCLES = 24;
    localparam int RANDOM_ITEMS = 600;
    localparam bit REQ_TICK = 1'b0;
    localparam bit REQ_KEY = 1'b1;
    localparam logic [7:0] KEY_SPACE = 8'h20;
    localparam logic [7:0] KEY_COLON = 8'h3a;
    localparam logic [7:0] KEY_DOT = 8'h2e;
    localparam logic [7:0] KEY_ZERO = 8'h30;
    localparam logic [7:0] KEY_LOW_Q = 8'h71;
    localparam logic [7:0] KEY_UP_Q = 8'h51;
    localparam logic [7:0] KEY_LOW_P = 8'h70;
    localparam logic [7:0] KEY_UP_P = 8'h50;
    localparam logic [7:0] KEY_LOW_N = 8'h6e;
    localparam logic [7:0] KEY_UP_N = 8'h4e;
    localparam logic [7:0] KEY_LOW_S = 8'h73;
    localparam logic [7:0] KEY_UP_S = 8'h53;
    localparam logic [7:0] KEY_LOW_M = 8'h6d;
    localparam logic [7:0] KEY_UP_M = 8'h4d;
    localparam logic [7:0] KEY_OTHER = 8'h78;
    localparam logic [63:0] CAP40 = 64'h100_0000_0000;

    typedef struct {
        logic        mode;
        logic [2:0]  phase;
        logic [31:0] tms;
        logic        beep;
        logic        quit;
        logic        bad;
        logic [3:0]  len;
    } timer_out_t;

    typedef struct {
        bit          req;
        logic [7:0]  key;
        bit          typed;
        logic [2:0]  phase;
        logic [31:0] tms;
        logic        beep;
        logic        quit;
        logic        bad;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        req_type;
    logic [7:0]  key_code;
    logic        out_valid;
    logic        out_ready;
    logic        mode_now;
    logic [2:0]  phase_code;
    logic [31:0] time_ms;
    logic        beep;
    logic        quit_request;
    logic        entry_bad;
    logic [3:0]  entry_length;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    // predictor state
    logic [15:0] alarm_interval;
    logic        cur_mode;
    logic [2:0]  cur_phase;
    logic [31:0] total_ms;
    logic [31:0] base_ms;
    logic [31:0] run_ms;
    logic [15:0] alarm_count;
    logic [7:0]  entry_text [csc_pkg::ENTRY_MAX_DEF];
    logic [3:0]  entry_cnt;
    logic        entry_err;

    timer_out_t  pending_results[$];
    int          error_count;
    int          items_sent;
    int          results_seen;
    int          beeps_seen;
    int          idle_cycles;
    int          stall_left;
    bit          quiet;

    countdown_stopwatch_controller DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .key_code(key_code),
        .out_valid(out_valid), .out_ready(out_ready),
        .mode_now(mode_now), .phase_code(phase_code), .time_ms(time_ms),
        .beep(beep), .quit_request(quit_request),
        .entry_bad(entry_bad), .entry_length(entry_length),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic bit is_running();
        return cur_phase == csc_pkg::PH_RUN || cur_phase == csc_pkg::PH_SW_RUN;
    endfunction

    function automatic logic [31:0] elapsed_ms();
        logic [32:0] s;
        s = {1'b0, base_ms} + {1'b0, run_ms};
        if (!is_running())
            return base_ms;
        return s[32] ? 32'hffff_ffff : s[31:0];
    endfunction

    function automatic logic [63:0] clamp40(input logic [63:0] v);
        return (v > CAP40) ? CAP40 : v;
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= KEY_ZERO && c <= KEY_ZERO + 8'd9;
    endfunction

    function automatic bit decode_entry(output logic [31:0] ms);
        logic [63:0] sum;
        logic [63:0] seg;
        logic [7:0]  c;
        int          colons;
        int          dots;
        int          frac;
        bit          saw_digit;
        sum = 0; seg = 0; colons = 0; dots = 0; frac = 0; saw_digit = 0; ms = 0;
        if (entry_cnt == 0)
            return 0;
        for (int i = 0; i < entry_cnt; i++)
        begin
            c = entry_text[i];
            if (is_digit(c))
            begin
                saw_digit = 1;
                if (dots == 0)
                    seg = clamp40(seg * 10 + 64'(c - KEY_ZERO) * 1000);
                else if (dots == 1 && frac < 3)
                begin
                    seg = clamp40(seg + 64'(c - KEY_ZERO) * (frac == 0 ? 100 : frac == 1 ? 10 : 1));
                    frac++;
                end
            end
            else if (c == KEY_DOT)
            begin
                if (dots < 2)
                    dots++;
            end
            else if (c == KEY_COLON)
            begin
                if (colons >= 2)
                    return 0;
                sum = clamp40(sum * 60 + seg);
                seg = 0; dots = 0; frac = 0;
                colons++;
            end
            else
                return 0;
        end
        sum = clamp40(sum * 60 + seg);
        if (!saw_digit || sum == 0 || sum > 64'(csc_pkg::DAY_MS))
            return 0;
        ms = sum[31:0];
        return 1;
    endfunction

    function automatic void go_idle();
        base_ms = 0;
        run_ms = 0;
        cur_phase = cur_mode ? csc_pkg::PH_SW_IDLE : csc_pkg::PH_IDLE;
    endfunction

    function automatic void start_stop();
        case (cur_phase)
            csc_pkg::PH_IDLE, csc_pkg::PH_PAUSED:
            begin
                run_ms = 0; cur_phase = csc_pkg::PH_RUN;
            end
            csc_pkg::PH_SW_IDLE, csc_pkg::PH_SW_PAUSED:
            begin
                run_ms = 0; cur_phase = csc_pkg::PH_SW_RUN;
            end
            csc_pkg::PH_RUN:
            begin
                base_ms = elapsed_ms(); run_ms = 0; cur_phase = csc_pkg::PH_PAUSED;
            end
            csc_pkg::PH_SW_RUN:
            begin
                base_ms = elapsed_ms(); run_ms = 0; cur_phase = csc_pkg::PH_SW_PAUSED;
            end
            csc_pkg::PH_FINISHED:
            begin
                base_ms = 0; run_ms = 0; cur_phase = csc_pkg::PH_IDLE;
            end
            default: ;
        endcase
    endfunction

    function automatic void entry_key(input logic [7:0] k);
        logic [31:0] ms;
        if (k == csc_pkg::K_ESC)
        begin
            entry_cnt = 0; entry_err = 0; cur_phase = csc_pkg::PH_IDLE;
        end
        else if (k == csc_pkg::K_LF || k == csc_pkg::K_CR)
        begin
            if (decode_entry(ms))
            begin
                total_ms = ms; base_ms = 0; run_ms = 0; cur_phase = csc_pkg::PH_IDLE;
            end
            else
                entry_err = 1;
        end
        else if (k == csc_pkg::K_DEL || k == csc_pkg::K_BS)
        begin
            if (entry_cnt > 0)
                entry_cnt--;
            entry_err = 0;
        end
        else if (is_digit(k) || k == KEY_COLON || k == KEY_DOT)
        begin
            if (entry_cnt < csc_pkg::ENTRY_MAX_DEF)
            begin
                entry_text[entry_cnt] = k;
                entry_cnt++;
            end
            entry_err = 0;
        end
    endfunction

    function automatic void command_key(input logic [7:0] k);
        case (k)
            KEY_SPACE, KEY_LOW_P, KEY_UP_P: start_stop();
            KEY_LOW_N, KEY_UP_N:
                if (!cur_mode)
                begin
                    run_ms = 0; entry_cnt = 0; entry_err = 0; cur_phase = csc_pkg::PH_SETTING;
                end
            KEY_LOW_S, KEY_UP_S: go_idle();
            KEY_LOW_M, KEY_UP_M:
            begin
                cur_mode = ~cur_mode; go_idle();
            end
            default: ;
        endcase
    endfunction

    function automatic timer_out_t advance_timer(input bit req, input logic [7:0] k);
        timer_out_t  r;
        logic [31:0] el;
        r.beep = 0;
        r.quit = 0;
        if (req == REQ_TICK)
        begin
            if (is_running() && run_ms != 32'hffff_ffff)
                run_ms++;
            if (cur_phase == csc_pkg::PH_FINISHED)
            begin
                if (alarm_count >= alarm_interval)
                begin
                    r.beep = 1; alarm_count = 0;
                end
                else
                    alarm_count++;
            end
        end
        else if (k == KEY_LOW_Q || k == KEY_UP_Q || k == csc_pkg::K_ETX || k == csc_pkg::K_EOT)
            r.quit = 1;
        else if (cur_phase == csc_pkg::PH_SETTING)
            entry_key(k);
        else
            command_key(k);
        // expiry of a running countdown
        if (!r.quit && !cur_mode && is_running() && elapsed_ms() >= total_ms)
        begin
            base_ms = total_ms; run_ms = 0; cur_phase = csc_pkg::PH_FINISHED;
            alarm_count = 0; r.beep = 1;
        end
        el = elapsed_ms();
        r.mode = cur_mode;
        r.phase = cur_phase;
        r.tms = cur_mode ? el : (el < total_ms ? total_ms - el : 32'd0);
        r.bad = entry_err;
        r.len = entry_cnt;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // send one transaction and record what it should produce
    task automatic send_item(input bit req, input logic [7:0] k, input bit typed = 0,
                             input stim_row_t row = '{default: 0});
        timer_out_t exp_r;
        int gap;
        in_valid <= 1'b1;
        req_type <= req;
        key_code <= k;
        do
            @(posedge clk);
        while (!in_ready);
        exp_r = advance_timer(req, k);
        if (typed)
        begin
            exp_r.phase = row.phase;
            exp_r.tms = row.tms;
            exp_r.beep = row.beep;
            exp_r.quit = row.quit;
            exp_r.bad = row.bad;
        end
        pending_results.push_back(exp_r);
        items_sent++;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_alarm(input logic [15:0] v);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        alarm_interval = v;
    endtask

    task automatic run_ticks(input int n);
        for (int i = 0; i < n; i++)
            send_item(REQ_TICK, 8'($urandom));
    endtask

    // a countdown from entry to expiry, with a few reminder ticks after
    task automatic countdown_session();
        int n;
        logic [7:0] c;
        if (cur_mode)
            send_item(REQ_KEY, KEY_LOW_M);
        send_item(REQ_KEY, $urandom_range(0, 1) ? KEY_LOW_N : KEY_UP_N);
        if ($urandom_range(0, 3) != 0)
        begin
            // short durations so expiry comes soon
            send_item(REQ_KEY, KEY_ZERO);
            send_item(REQ_KEY, KEY_DOT);
            send_item(REQ_KEY, KEY_ZERO);
            n = $urandom_range(1, 2);
            for (int i = 0; i < n; i++)
                send_item(REQ_KEY, KEY_ZERO + 8'($urandom_range(i == n - 1 ? 1 : 0, 9)));
        end
        else
        begin
            n = $urandom_range(0, 14);
            for (int i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 9))
                    0: c = KEY_COLON;
                    1: c = KEY_DOT;
                    2: c = $urandom_range(0, 1) ? csc_pkg::K_DEL : csc_pkg::K_BS;
                    3: c = 8'($urandom);
                    default: c = KEY_ZERO + 8'($urandom_range(0, 9));
                endcase
                send_item(REQ_KEY, c);
            end
        end
        send_item(REQ_KEY, $urandom_range(0, 1) ? csc_pkg::K_CR : csc_pkg::K_LF);
        if (cur_phase == csc_pkg::PH_SETTING)
            send_item(REQ_KEY, csc_pkg::K_ESC);
        send_item(REQ_KEY, KEY_SPACE);
        n = 0;
        while (cur_phase == csc_pkg::PH_RUN && n < 150)
        begin
            if ($urandom_range(0, 15) == 0)
                send_item(REQ_KEY, KEY_LOW_P);
            else
            begin
                send_item(REQ_TICK, 8'($urandom));
                n++;
            end
            if (cur_phase == csc_pkg::PH_PAUSED)
                send_item(REQ_KEY, KEY_UP_P);
        end
        run_ticks($urandom_range(0, 8));
        if ($urandom_range(0, 1))
            send_item(REQ_KEY, KEY_SPACE);
    endtask

    task automatic stopwatch_session();
        if (!cur_mode)
            send_item(REQ_KEY, KEY_UP_M);
        send_item(REQ_KEY, KEY_SPACE);
        run_ticks($urandom_range(1, 10));
        send_item(REQ_KEY, KEY_LOW_P);
        run_ticks($urandom_range(0, 3));
        send_item(REQ_KEY, KEY_SPACE);
        run_ticks($urandom_range(1, 6));
        if ($urandom_range(0, 1))
            send_item(REQ_KEY, $urandom_range(0, 1) ? KEY_LOW_S : KEY_UP_S);
    endtask

    task automatic noise_item();
        logic [7:0] picks [16] = '{KEY_SPACE, KEY_LOW_P, KEY_UP_P, KEY_LOW_N, KEY_UP_N,
            KEY_LOW_S, KEY_UP_S, KEY_LOW_M, KEY_UP_M, KEY_LOW_Q, KEY_UP_Q, csc_pkg::K_ETX,
            csc_pkg::K_EOT, csc_pkg::K_ESC, csc_pkg::K_CR, KEY_OTHER};
        if ($urandom_range(0, 1))
            send_item(REQ_KEY, picks[$urandom_range(0, 15)]);
        else
            send_item(1'($urandom), 8'($urandom));
    endtask

    // sink side: random stall bursts, checks every result
    always @(posedge clk)
    begin
        timer_out_t e;
        logic       nxt_ready;
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            nxt_ready = 1'b0;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 4);
            nxt_ready = 1'b0;
        end
        else
            nxt_ready = 1'b1;
        out_ready <= nxt_ready;

        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (beep)
                beeps_seen++;
            if (pending_results.size() == 0)
                report_mismatch("unexpected result transaction", 32'd1, 32'd0);
            else
            begin
                e = pending_results.pop_front();
                if (mode_now !== e.mode) report_mismatch("mode_now", mode_now, e.mode);
                if (phase_code !== e.phase) report_mismatch("phase_code", phase_code, e.phase);
                if (time_ms !== e.tms) report_mismatch("time_ms", time_ms, e.tms);
                if (beep !== e.beep) report_mismatch("beep", beep, e.beep);
                if (quit_request !== e.quit)
                    report_mismatch("quit_request", quit_request, e.quit);
                if (entry_bad !== e.bad) report_mismatch("entry_bad", entry_bad, e.bad);
                if (entry_length !== e.len)
                    report_mismatch("entry_length", entry_length, e.len);
            end
        end

        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= TIMEOUT_CYCLES)
        begin
            $display("watchdog expired, no transaction for %0d cycles", idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        stim_row_t directed[$];
        logic [15:0] alarm_plan[5];
        int goal;

        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = REQ_TICK;
        key_code = 8'd0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 16'd0;
        error_count = 0; items_sent = 0; results_seen = 0; beeps_seen = 0;
        idle_cycles = 0; stall_left = 0; quiet = 0;
        alarm_interval = csc_pkg::ALARM_RESET;
        cur_mode = 0; cur_phase = csc_pkg::PH_IDLE; total_ms = 32'(csc_pkg::TOTAL_RESET);
        base_ms = 0; run_ms = 0; alarm_count = 0; entry_cnt = 0; entry_err = 0;
        foreach (entry_text[i])
            entry_text[i] = 8'd0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // req, key, typed, phase, time, beep, quit, bad
        directed = '{
            '{REQ_TICK, 8'hff, 1, csc_pkg::PH_IDLE, 32'd300000, 0, 0, 0},
            '{REQ_KEY, KEY_LOW_Q, 1, csc_pkg::PH_IDLE, 32'd300000, 0, 1, 0},
            '{REQ_KEY, KEY_UP_Q, 0, 0, 0, 0, 0, 0},
            '{REQ_KEY, csc_pkg::K_ETX, 0, 0, 0, 0, 0, 0},
            '{REQ_KEY, csc_pkg::K_EOT, 0, 0, 0, 0, 0, 0},
            '{REQ_KEY, KEY_LOW_N, 1, csc_pkg::PH_SETTING, 32'd300000, 0, 0, 0},
            '{REQ_KEY, csc_pkg::K_LF, 1, csc_pkg::PH_SETTING, 32'd300000, 0, 0, 1},
            '{REQ_KEY, KEY_ZERO, 0, 0, 0, 0, 0, 0},
            '{REQ_KEY, KEY_DOT, 0, 0, 0, 0, 0, 0},
            '{REQ_KEY, KEY_ZERO + 8'd9, 0, 0, 0, 0, 0, 0},
            '{REQ_KEY, csc_pkg::K_DEL, 0, 0, 0, 0, 0, 0},
            '{REQ_KEY, KEY_ZERO, 0, 0, 0, 0, 0, 0},
            '{REQ_KEY, KEY_ZERO + 8'd2, 0, 0, 0, 0, 0, 0},
            '{REQ_KEY, KEY_COLON, 0, 0, 0, 0, 0, 0},
            '{REQ_KEY, csc_pkg::K_BS, 0, 0, 0, 0, 0, 0},
            '{REQ_KEY, csc_pkg::K_CR, 1, csc_pkg::PH_IDLE, 32'd20, 0, 0, 0},
            '{REQ_KEY, KEY_SPACE, 0, 0, 0, 0, 0, 0},
            '{REQ_KEY, KEY_LOW_N, 0, 0, 0, 0, 0, 0},
            '{REQ_KEY, KEY_ZERO + 8'd7, 0, 0, 0, 0, 0, 0},
            '{REQ_KEY, csc_pkg::K_ESC, 1, csc_pkg::PH_IDLE, 32'd20, 0, 0, 0},
            '{REQ_KEY, KEY_UP_M, 1, csc_pkg::PH_SW_IDLE, 32'd0, 0, 0, 0},
            '{REQ_KEY, KEY_UP_P, 0, 0, 0, 0, 0, 0},
            '{REQ_TICK, 8'h00, 1, csc_pkg::PH_SW_RUN, 32'd1, 0, 0, 0},
            '{REQ_KEY, KEY_UP_N, 0, 0, 0, 0, 0, 0},
            '{REQ_KEY, KEY_LOW_M, 1, csc_pkg::PH_IDLE, 32'd20, 0, 0, 0}
        };
        foreach (directed[i])
            send_item(directed[i].req, directed[i].key, directed[i].typed, directed[i]);

        alarm_plan = '{16'd1, 16'd65535, 16'd3, 16'($urandom_range(1, 40)), 16'd2};
        goal = items_sent;
        foreach (alarm_plan[p])
        begin
            write_alarm(alarm_plan[p]);
            goal += RANDOM_ITEMS / 5;
            while (items_sent < goal)
            begin
                quiet = (p == 4) && (goal - items_sent < RANDOM_ITEMS / 10);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: countdown_session();
                    5, 6: stopwatch_session();
                    default: noise_item();
                endcase
            end
        end
        quiet = 1;
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d transactions in, %0d results checked, %0d beeps seen",
                 items_sent, results_seen, beeps_seen);
        $display("covered countdown entry and expiry, reminders at five alarm intervals, stopwatch");
        if (error_count == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[countdown_stopwatch_controller.f]
rtl/csc_pkg.sv
rtl/csc_parser.sv
rtl/countdown_stopwatch_controller.sv
rtl/csc_checker.sv
verif/testbench.sv
